// ===== hw/rtl/booth_radix2_multiplier_core_macros.svh =====
// Assertion macros for the Booth multiplier core.
`ifndef BOOTH_RADIX2_MULTIPLIER_CORE_MACROS_SVH
`define BOOTH_RADIX2_MULTIPLIER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BMUL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmul check failed");

// Next-cycle implication, checked out of reset.
`define BMUL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmul check failed");

`endif

// ===== hw/rtl/bmul_pkg.sv =====
`default_nettype none

package bmul_pkg;

    localparam int OP_W   = 32;
    localparam int PROD_W = 64;

    typedef enum logic [1:0] {
        BOOTH_NOP,
        BOOTH_ADD,
        BOOTH_SUB
    } booth_op_t;

    typedef struct packed {
        logic valid;
    } stage_ctrl_t;

    // Radix-2 recode of {current bit, previous bit}.
    function automatic booth_op_t booth_decode(input logic cur, input logic prev);
        booth_op_t op;
        unique case ({cur, prev})
            2'b00: op = BOOTH_NOP;
            2'b01: op = BOOTH_ADD;
            2'b10: op = BOOTH_SUB;
            2'b11: op = BOOTH_NOP;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bmul_step.sv =====
`default_nettype none

// One Booth step: add/sub multiplicand into the high half, then shift the
// {acc, q} pair right arithmetically by one. Fully registered.
module bmul_step #(
    parameter int WIDTH = 32
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire bmul_pkg::stage_ctrl_t in_ctrl,
    input  wire logic [WIDTH:0]     in_acc,
    input  wire logic [WIDTH-1:0]   in_q,
    input  wire logic               in_prev,
    input  wire logic [WIDTH-1:0]   in_mcand,
    output bmul_pkg::stage_ctrl_t   out_ctrl,
    output logic [WIDTH:0]          out_acc,
    output logic [WIDTH-1:0]        out_q,
    output logic                    out_prev,
    output logic [WIDTH-1:0]        out_mcand
);

    bmul_pkg::stage_ctrl_t ctrl_reg;
    logic [WIDTH:0]        acc_reg,   acc_next;
    logic [WIDTH-1:0]      q_reg,     q_next;
    logic                  prev_reg,  prev_next;
    logic [WIDTH-1:0]      mcand_reg;

    bmul_pkg::booth_op_t   op;
    logic [WIDTH:0]        mc_ext;
    logic [WIDTH:0]        sum;

    always_comb
    begin
        op     = bmul_pkg::booth_decode(in_q[0], in_prev);
        mc_ext = {in_mcand[WIDTH-1], in_mcand};
        unique case (op)
            bmul_pkg::BOOTH_ADD: sum = in_acc + mc_ext;
            bmul_pkg::BOOTH_SUB: sum = in_acc - mc_ext;
            default:             sum = in_acc;
        endcase
        acc_next  = {sum[WIDTH], sum[WIDTH:1]};
        q_next    = {sum[0], in_q[WIDTH-1:1]};
        prev_next = in_q[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= in_ctrl;
        end
    end

    // datapath: no reset
    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        q_reg     <= q_next;
        prev_reg  <= prev_next;
        mcand_reg <= in_mcand;
    end

    assign out_ctrl  = ctrl_reg;
    assign out_acc   = acc_reg;
    assign out_q     = q_reg;
    assign out_prev  = prev_reg;
    assign out_mcand = mcand_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/booth_radix2_multiplier_core.sv =====
`default_nettype none

// Signed radix-2 Booth multiplier, fully pipelined. Each word carries two
// two's complement operands; only their low WIDTH bits are used, taken as
// signed WIDTH-bit values. A word is taken at every rising edge where start
// is high (busy is never raised), so one word per cycle is sustained with no
// gaps. Each word passes through a pipeline of WIDTH Booth step stages, one
// add/subtract and shift per stage. As the result leaves the last stage, done
// is high for one cycle and product holds the exact 2*WIDTH-bit result,
// sign-extended to 64 bits. Results must be captured in the cycle
// done is high; there is no backpressure and nothing is buffered. Overflow
// cannot occur. No state survives between words, and reset only clears the
// stage valid bits.

`include "booth_radix2_multiplier_core_macros.svh"

module booth_radix2_multiplier_core #(
    parameter int WIDTH = 32
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     start,
    output logic                                    busy,
    input  wire logic signed [bmul_pkg::OP_W-1:0]   multiplicand,
    input  wire logic signed [bmul_pkg::OP_W-1:0]   multiplier,
    output logic                                    done,
    output logic signed [bmul_pkg::PROD_W-1:0]      product
);

    localparam int FULL_W = 2 * WIDTH + 1;

    // Stage k input is index k; index WIDTH is the last stage output.
    bmul_pkg::stage_ctrl_t stg_ctrl  [0:WIDTH];
    logic [WIDTH:0]        stg_acc   [0:WIDTH];
    logic [WIDTH-1:0]      stg_q     [0:WIDTH];
    logic                  stg_prev  [0:WIDTH];
    logic [WIDTH-1:0]      stg_mcand [0:WIDTH];

    logic signed [FULL_W-1:0] full_prod;

    // Pipeline never stalls.
    assign busy = 1'b0;

    // Entry: accumulator cleared, implied bit below the multiplier is zero.
    assign stg_ctrl[0].valid = start & ~busy;
    assign stg_acc[0]        = '0;
    assign stg_q[0]          = multiplier[WIDTH-1:0];
    assign stg_prev[0]       = 1'b0;
    assign stg_mcand[0]      = multiplicand[WIDTH-1:0];

    for (genvar k = 0; k < WIDTH; k++)
    begin : g_step
        bmul_step #(
            .WIDTH(WIDTH)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_ctrl  (stg_ctrl[k]),
            .in_acc   (stg_acc[k]),
            .in_q     (stg_q[k]),
            .in_prev  (stg_prev[k]),
            .in_mcand (stg_mcand[k]),
            .out_ctrl (stg_ctrl[k+1]),
            .out_acc  (stg_acc[k+1]),
            .out_q    (stg_q[k+1]),
            .out_prev (stg_prev[k+1]),
            .out_mcand(stg_mcand[k+1])
        );
    end

    // {acc, q} after the last step is the product; size cast sign-extends
    // (or drops the redundant top sign bit at WIDTH = 32).
    assign full_prod = {stg_acc[WIDTH], stg_q[WIDTH]};
    assign product   = bmul_pkg::PROD_W'(full_prod);
    assign done      = stg_ctrl[WIDTH].valid;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    logic signed [bmul_pkg::PROD_W-1:0] chk_mcand;
    logic signed [bmul_pkg::PROD_W-1:0] chk_mplier;

    assign chk_mcand  = bmul_pkg::PROD_W'($signed(multiplicand[WIDTH-1:0]));
    assign chk_mplier = bmul_pkg::PROD_W'($signed(multiplier[WIDTH-1:0]));

    // A result only appears for a word that was taken at the pipeline entry.
    `BMUL_ASSERT_IMPLY(a_done_src, clk, rst_n, done, $past(start, WIDTH))
    // The result is the exact signed product of that word.
    `BMUL_ASSERT_IMPLY(a_prod_exact, clk, rst_n, done,
        product == $past(chk_mcand, WIDTH) * $past(chk_mplier, WIDTH))
    // Product fits 2*WIDTH bits: bits above are pure sign.
    `BMUL_ASSERT_IMPLY(a_prod_fits, clk, rst_n, done,
        product == bmul_pkg::PROD_W'($signed(product[2*WIDTH-1:0])))
    // An accepted word enters the first stage.
    `BMUL_ASSERT_NEXT(a_entry, clk, rst_n, start && !busy, stg_ctrl[1].valid)

endmodule

`default_nettype wire
